/* rtl/pidc_pkg.sv */
// Shared types and constants for the PID controller.
package pidc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned ILIM_W     = 31;
    localparam int unsigned OLIM_W     = 15;
    localparam int unsigned INTEG_W    = 32;
    localparam int unsigned ERR_W      = 17;
    localparam int unsigned FRAC_W     = 12;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [GAIN_W-1:0]   t_gain;

    typedef enum logic {
        OP_STEP  = 1'b0,
        OP_CLEAR = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP     = 3'd0,
        CFG_KI_DT  = 3'd1,
        CFG_KD_DT  = 3'd2,
        CFG_ILIMIT = 3'd3,
        CFG_OLIMIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic advance;
        logic clear;
    } t_integ_ctl;

endpackage

/* rtl/pidc_in_if.sv */
// Command channel: opcode plus reference and feedback samples.
interface pidc_in_if import pidc_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    opcode;
    t_sample reference;
    t_sample feedback;

    modport source (output valid, output opcode, output reference, output feedback,
                    input ready);
    modport sink   (input valid, input opcode, input reference, input feedback,
                    output ready);
endinterface

/* rtl/pidc_out_if.sv */
// Result channel: controller drive and clamp flag.
interface pidc_out_if import pidc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample control_output;
    logic    output_clamped;

    modport source (output valid, output control_output, output output_clamped,
                    input ready);
    modport sink   (input valid, input control_output, input output_clamped,
                    output ready);
endinterface

/* rtl/pidc_cfg_if.sv */
// Configuration write channel: register index and write data.
interface pidc_cfg_if import pidc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pidc_integ.sv */
// Integral accumulator with symmetric clamp or 32-bit saturation.
module pidc_integ import pidc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_integ_ctl                i_ctl,
    input  logic signed [28:0]        i_incr,
    input  logic [ILIM_W-1:0]         i_limit,
    output logic signed [INTEG_W-1:0] o_next,
    output logic signed [INTEG_W-1:0] o_integral
);

    logic signed [INTEG_W-1:0] r_integral;
    logic signed [INTEG_W-1:0] n_integral;
    logic signed [INTEG_W:0]   w_sum;
    logic signed [INTEG_W:0]   w_lim;

    assign w_sum = (INTEG_W+1)'(r_integral) + (INTEG_W+1)'(i_incr);
    assign w_lim = $signed({2'b00, i_limit});

    always_comb begin
        if (i_ctl.clear) begin
            n_integral = '0;
        end else if (i_limit != '0) begin
            if (w_sum > w_lim) begin
                n_integral = INTEG_W'(w_lim);
            end else if (w_sum < -w_lim) begin
                n_integral = INTEG_W'(-w_lim);
            end else begin
                n_integral = INTEG_W'(w_sum);
            end
        end else begin
            if (w_sum > (INTEG_W+1)'(33'sd2147483647)) begin
                n_integral = {1'b0, {(INTEG_W-1){1'b1}}};
            end else if (w_sum < -(INTEG_W+1)'(33'sd2147483648)) begin
                n_integral = {1'b1, {(INTEG_W-1){1'b0}}};
            end else begin
                n_integral = INTEG_W'(w_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (i_ctl.advance) begin
            r_integral <= n_integral;
        end
    end

    assign o_next     = n_integral;
    assign o_integral = r_integral;

endmodule

/* rtl/pid_controller.sv */
// Top level of the positional PID controller with integral and output clamps.
// One transaction per clock is accepted and one result per clock is delivered while
// the result channel is ready. A result passes four registers: input register,
// product register (the three gain multiplies), integral register (the
// accumulate-and-clamp loop), and output register. Each stage holds its item under
// backpressure, so the channel keeps accepting while a finished result waits, until
// all four stages are full. Configuration writes take effect at once and are always
// accepted; write them only while no command is in flight.
module pid_controller import pidc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidc_cfg_if.sink   i_cfg,
    pidc_in_if.sink    i_cmd,
    pidc_out_if.source o_res
);

    // configuration
    t_gain               r_kp;
    t_gain               r_ki;
    t_gain               r_kd;
    logic [ILIM_W-1:0]   r_ilim;
    logic [OLIM_W-1:0]   r_olim;

    // pipeline valids and handshakes
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_acc, w_mv1, w_mv2, w_mv3;
    logic w_rdy2, w_rdy3, w_rdy4;

    // stage 1
    logic    r_s1_op;
    t_sample r_s1_ref;
    t_sample r_s1_fb;

    // stage 2
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [ERR_W-1:0] w_err;
    logic signed [ERR_W:0]   w_delta;
    logic signed [40:0]      w_p_prod;
    logic signed [40:0]      w_i_prod;
    logic signed [41:0]      w_d_prod;
    logic signed [28:0]      r_s2_p;
    logic signed [28:0]      r_s2_i;
    logic signed [29:0]      r_s2_d;
    logic                    r_s2_clr;

    // stage 3
    t_integ_ctl                w_ictl;
    logic signed [INTEG_W-1:0] w_int_next;
    logic signed [INTEG_W-1:0] w_integral;
    logic signed [INTEG_W-1:0] r_s3_int;
    logic signed [30:0]        r_s3_pd;
    logic                      r_s3_clr;

    // stage 4
    logic signed [32:0] w_sum;
    logic signed [32:0] w_olim;
    t_sample            n_out;
    logic               n_hit;
    t_sample            r_out;
    logic               r_hit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_ilim <= '0;
            r_olim <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KP:     r_kp   <= GAIN_W'(i_cfg.data);
                CFG_KI_DT:  r_ki   <= GAIN_W'(i_cfg.data);
                CFG_KD_DT:  r_kd   <= GAIN_W'(i_cfg.data);
                CFG_ILIMIT: r_ilim <= ILIM_W'(i_cfg.data);
                CFG_OLIMIT: r_olim <= OLIM_W'(i_cfg.data);
                default: ;
            endcase
        end
    end

    assign w_rdy4      = !r_v4 || o_res.ready;
    assign w_mv3       = r_v3 && w_rdy4;
    assign w_rdy3      = !r_v3 || w_rdy4;
    assign w_mv2       = r_v2 && w_rdy3;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_mv1       = r_v1 && w_rdy2;
    assign i_cmd.ready = !r_v1 || w_rdy2;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_acc || (r_v1 && !w_mv1);
            r_v2 <= w_mv1 || (r_v2 && !w_mv2);
            r_v3 <= w_mv2 || (r_v3 && !w_mv3);
            r_v4 <= w_mv3 || (r_v4 && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_op  <= i_cmd.opcode;
            r_s1_ref <= i_cmd.reference;
            r_s1_fb  <= i_cmd.feedback;
        end
    end

    // error, delta and the three products; >>> 12 floors
    assign w_err    = ERR_W'(r_s1_ref) - ERR_W'(r_s1_fb);
    assign w_delta  = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_prev_err);
    assign w_p_prod = 41'(r_kp) * 41'(w_err);
    assign w_i_prod = 41'(r_ki) * 41'(w_err);
    assign w_d_prod = 42'(r_kd) * 42'(w_delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (w_mv1) begin
            r_prev_err <= (r_s1_op == OP_CLEAR) ? '0 : w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv1) begin
            r_s2_p   <= 29'(w_p_prod >>> FRAC_W);
            r_s2_i   <= 29'(w_i_prod >>> FRAC_W);
            r_s2_d   <= 30'(w_d_prod >>> FRAC_W);
            r_s2_clr <= (r_s1_op == OP_CLEAR);
        end
    end

    assign w_ictl.advance = w_mv2;
    assign w_ictl.clear   = r_s2_clr;

    pidc_integ u_integ (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ictl),
        .i_incr     (r_s2_i),
        .i_limit    (r_ilim),
        .o_next     (w_int_next),
        .o_integral (w_integral)
    );

    always_ff @(posedge i_clk) begin
        if (w_mv2) begin
            r_s3_int <= w_int_next;
            r_s3_pd  <= 31'(r_s2_p) + 31'(r_s2_d);
            r_s3_clr <= r_s2_clr;
        end
    end

    assign w_sum  = 33'(r_s3_pd) + 33'(r_s3_int);
    assign w_olim = $signed({18'b0, r_olim});

    always_comb begin
        n_out = '0;
        n_hit = 1'b0;
        if (!r_s3_clr) begin
            if (r_olim != '0) begin
                if (w_sum > w_olim) begin
                    n_out = SAMPLE_W'(w_olim);
                    n_hit = 1'b1;
                end else if (w_sum < -w_olim) begin
                    n_out = SAMPLE_W'(-w_olim);
                    n_hit = 1'b1;
                end else begin
                    n_out = SAMPLE_W'(w_sum);
                end
            end else begin
                if (w_sum > 33'sd32767) begin
                    n_out = 16'sh7FFF;
                    n_hit = 1'b1;
                end else if (w_sum < -33'sd32768) begin
                    n_out = 16'sh8000;
                    n_hit = 1'b1;
                end else begin
                    n_out = SAMPLE_W'(w_sum);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv3) begin
            r_out <= n_out;
            r_hit <= n_hit;
        end
    end

    assign o_res.valid          = r_v4;
    assign o_res.control_output = r_out;
    assign o_res.output_clamped = r_hit;

    a_integ_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv2 && r_s2_clr) |=> (w_integral == '0))
        else $error("integral not cleared by clear command");

    a_prev_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv1 && (r_s1_op == OP_CLEAR)) |=> (r_prev_err == '0))
        else $error("previous error not cleared by clear command");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v1)
        else $error("accepted transaction lost at input stage");

endmodule
